// ===== rtl/i2d_pkg.sv =====
package i2d_pkg;

  localparam int DIGITS_PER_WORD = 4;

  localparam int DPW_CLAMPED = (DIGITS_PER_WORD < 1) ? 1 :
                               (DIGITS_PER_WORD > 4) ? 4 : DIGITS_PER_WORD;

  localparam int RADIX = (DPW_CLAMPED == 1) ? 10 :
                         (DPW_CLAMPED == 2) ? 100 :
                         (DPW_CLAMPED == 3) ? 1000 : 10000;

  localparam int HALF_W      = 64;
  localparam int MAG_W       = 2 * HALF_W;
  localparam int LIMB_W      = 16;
  localparam int NUM_LIMBS   = MAG_W / LIMB_W;
  localparam int LIMB_CNT_W  = $clog2(NUM_LIMBS);
  localparam int REM_W       = $clog2(RADIX);
  localparam int CUR_W       = REM_W + LIMB_W;
  localparam int RECIP_SHIFT = CUR_W + REM_W;
  localparam int RECIP_W     = CUR_W + 1;
  localparam int PROD_W      = CUR_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / RADIX);
  localparam logic [CUR_W-1:0]   RADIX_CUR = CUR_W'(RADIX);

  localparam int DIGIT_W     = 14;
  localparam int POS_W       = 4;
  localparam int MAX_RESULTS = 10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_FIX,
    S_EMIT
  } i2d_state_e;

endpackage

// ===== rtl/i2d_limb_div.sv =====
module i2d_limb_div
  import i2d_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CUR_W-1:0]  cur_i,
  output logic [LIMB_W-1:0] quot_o,
  output logic [REM_W-1:0]  rem_o
);

  logic [PROD_W-1:0] prod_q;
  logic [CUR_W-1:0]  cur_q;
  logic [LIMB_W-1:0] q_est;
  logic [CUR_W-1:0]  r_wide;

  // The reciprocal estimate is exact or one too small, so one correction suffices.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(cur_i) * PROD_W'(RECIP);
      cur_q  <= cur_i;
    end
  end

  always_comb begin
    q_est  = prod_q[RECIP_SHIFT +: LIMB_W];
    r_wide = cur_q - (CUR_W'(q_est) * RADIX_CUR);
    if (r_wide >= RADIX_CUR) begin
      quot_o = q_est + LIMB_W'(1);
      rem_o  = REM_W'(r_wide - RADIX_CUR);
    end else begin
      quot_o = q_est;
      rem_o  = REM_W'(r_wide);
    end
  end

endmodule

// ===== rtl/int128_to_base10000_digits.sv =====
// Converts a signed 128-bit integer into base-10000 digits, least significant
// digit first, one output item per digit, with the most significant digit
// flagged last; a zero input gives a single item with is_zero set. The
// magnitude is divided by 10000 in a single shared limb divider that takes
// 16 bits per pass, a pass being a multiply state and a fix state, so each
// digit takes eight passes and then an emit state, which waits while the
// output register is full and not taken. The block accepts one item at a time and
// holds in_ready_o low until the last digit has been handed to the output
// register.
module int128_to_base10000_digits
  import i2d_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [HALF_W-1:0] value_high_i,
  input  logic [HALF_W-1:0]        value_low_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DIGIT_W-1:0]       digit_o,
  output logic [POS_W-1:0]         position_o,
  output logic                     negative_o,
  output logic                     is_zero_o,
  output logic                     last_o
);

  localparam logic [LIMB_CNT_W-1:0] LAST_LIMB = LIMB_CNT_W'(NUM_LIMBS - 1);
  localparam logic [POS_W-1:0]      LAST_POS  = POS_W'(MAX_RESULTS - 1);

  i2d_state_e state_q, state_d;

  logic [MAG_W-1:0]      mag_q;
  logic [MAG_W-1:0]      mag_in;
  logic [REM_W-1:0]      rem_q;
  logic                  sign_q;
  logic                  zero_q;
  logic [POS_W-1:0]      pos_q;
  logic [LIMB_CNT_W-1:0] limb_cnt_q;
  logic                  out_valid_q;
  logic [DIGIT_W-1:0]    digit_q;
  logic [POS_W-1:0]      position_q;
  logic                  negative_q;
  logic                  is_zero_q;
  logic                  last_q;

  logic                  in_accept;
  logic                  div_en;
  logic                  emit_fire;
  logic                  emit_last;
  logic [CUR_W-1:0]      div_cur;
  logic [LIMB_W-1:0]     div_quot;
  logic [REM_W-1:0]      div_rem;

  assign mag_in = value_high_i[HALF_W-1] ? (~{value_high_i, value_low_i} + MAG_W'(1))
                                         : {value_high_i, value_low_i};
  assign div_cur   = {rem_q, mag_q[MAG_W-1 -: LIMB_W]};
  assign emit_last = (mag_q == '0) || (pos_q == LAST_POS);

  i2d_limb_div u_div (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .cur_i  (div_cur),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (mag_in == '0) ? S_EMIT : S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_FIX;
      end
      S_FIX: begin
        if (limb_cnt_q == LAST_LIMB) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = emit_last ? S_IDLE : S_MUL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_en     = 1'b0;
    emit_fire  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_MUL: begin
        div_en = 1'b1;
      end
      S_FIX: begin
      end
      S_EMIT: begin
        emit_fire = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      limb_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        pos_q      <= '0;
        limb_cnt_q <= '0;
      end else if (state_q == S_FIX) begin
        limb_cnt_q <= limb_cnt_q + LIMB_CNT_W'(1);
      end else if (emit_fire) begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q  <= mag_in;
      rem_q  <= '0;
      sign_q <= value_high_i[HALF_W-1];
      zero_q <= (mag_in == '0);
    end else if (state_q == S_FIX) begin
      mag_q <= {mag_q[MAG_W-LIMB_W-1:0], div_quot};
      rem_q <= div_rem;
    end else if (emit_fire) begin
      rem_q <= '0;
    end
    if (emit_fire) begin
      digit_q    <= DIGIT_W'(rem_q);
      position_q <= pos_q;
      negative_q <= sign_q;
      is_zero_q  <= zero_q;
      last_q     <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign digit_o     = digit_q;
  assign position_o  = position_q;
  assign negative_o  = negative_q;
  assign is_zero_o   = is_zero_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_zero_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_zero_o |-> digit_o == '0 && position_o == '0 && last_o && !negative_o)
    else $error("zero item has wrong fields");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digit_o < DIGIT_W'(RADIX))
    else $error("digit out of range");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIX |-> div_rem < REM_W'(RADIX))
    else $error("divider remainder out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted item");

  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && position_o == LAST_POS |-> last_o)
    else $error("run longer than the result limit");
`endif

endmodule

// ===== tb/int128_to_base10000_digits_tb.sv =====
`timescale 1ns / 100ps

module int128_to_base10000_digits_tb
  import i2d_pkg::*;
();

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 241;
  localparam int OUTPUT_HOLD    = 400;
  localparam int HOLD_AT_ITEM   = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic               negative;
    logic               is_zero;
    logic               last;
  } digit_item_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [HALF_W-1:0] value_high_i = '0;
  logic [HALF_W-1:0]        value_low_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [DIGIT_W-1:0]       digit_o;
  logic [POS_W-1:0]         position_o;
  logic                     negative_o;
  logic                     is_zero_o;
  logic                     last_o;

  logic [MAG_W-1:0] values_pending[$];
  digit_item_t      digits_expected[$];

  int total_values;
  int values_accepted = 0;
  int digits_checked = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_taken = 1'b0;

  int128_to_base10000_digits dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_high_i (value_high_i),
    .value_low_i  (value_low_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_o      (digit_o),
    .position_o   (position_o),
    .negative_o   (negative_o),
    .is_zero_o    (is_zero_o),
    .last_o       (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int sender_idle_pct(input int accepted);
    if (accepted < total_values / 3) return 20;
    if (accepted < 2 * total_values / 3) return 59;
    return 0;
  endfunction

  function automatic int receiver_idle_pct(input int accepted);
    if (accepted < total_values / 3) return 59;
    if (accepted < 2 * total_values / 3) return 20;
    return 0;
  endfunction

  function automatic logic [MAG_W-1:0] rand_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic expand_digits(input logic [MAG_W-1:0] value);
    logic [MAG_W-1:0] magnitude;
    logic             sign;
    digit_item_t      item;
    sign = value[MAG_W-1];
    magnitude = sign ? -value : value;
    if (magnitude == '0) begin
      item = '{digit: '0, position: '0, negative: 1'b0, is_zero: 1'b1, last: 1'b1};
      digits_expected.push_back(item);
      return;
    end
    for (int n = 0; n < MAX_RESULTS; n++) begin
      item.digit    = DIGIT_W'(magnitude % RADIX);
      magnitude     = magnitude / RADIX;
      item.position = POS_W'(n);
      item.negative = sign;
      item.is_zero  = 1'b0;
      item.last     = (magnitude == '0) || (n == MAX_RESULTS - 1);
      digits_expected.push_back(item);
      if (item.last) break;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [MAG_W-1:0] next_value;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      value_high_i <= '0;
      value_low_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expand_digits({value_high_i, value_low_i});
        values_accepted <= values_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (values_pending.size() > 0 &&
            $urandom_range(99) >= sender_idle_pct(values_accepted)) begin
          next_value = values_pending.pop_front();
          in_valid_i   <= 1'b1;
          value_high_i <= next_value[MAG_W-1:HALF_W];
          value_low_i  <= next_value[HALF_W-1:0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_taken && values_accepted >= HOLD_AT_ITEM) begin
      hold_taken  <= 1'b1;
      hold_left   <= OUTPUT_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct(values_accepted));
    end
  end

  always @(posedge clk_i) begin
    digit_item_t want;
    digit_item_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{digit: digit_o, position: position_o, negative: negative_o,
              is_zero: is_zero_o, last: last_o};
      if (digits_expected.size() == 0) begin
        $display("%0t: unexpected digit item digit=%0d position=%0d neg=%0b zero=%0b last=%0b",
                 $time, got.digit, got.position, got.negative, got.is_zero, got.last);
        error_count++;
      end else begin
        want = digits_expected.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected digit=%0d position=%0d neg=%0b zero=%0b last=%0b",
                   $time, want.digit, want.position, want.negative, want.is_zero,
                   want.last);
          $display("%0t:          actual   digit=%0d position=%0d neg=%0b zero=%0b last=%0b",
                   $time, got.digit, got.position, got.negative, got.is_zero, got.last);
          error_count++;
        end
        digits_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("int128_to_base10000_digits regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [MAG_W-1:0] ten_pow;
    logic [MAG_W-1:0] raw;
    int               bits;

    values_pending.push_back('0);
    values_pending.push_back(128'd1);
    values_pending.push_back(-128'sd1);
    values_pending.push_back(128'd9999);
    values_pending.push_back(128'd10000);
    values_pending.push_back(-128'sd10000);
    values_pending.push_back(128'd99999999);
    values_pending.push_back(128'd100000000);
    values_pending.push_back({64'd0, {64{1'b1}}});
    values_pending.push_back({64'd1, 64'd0});
    values_pending.push_back({{64{1'b1}}, 64'd0});
    values_pending.push_back({1'b0, {127{1'b1}}});
    values_pending.push_back({1'b1, 127'd0});
    values_pending.push_back({1'b1, 126'd0, 1'b1});
    ten_pow = 128'd1;
    repeat (36) ten_pow = ten_pow * 10;
    values_pending.push_back(ten_pow - 1);
    values_pending.push_back(ten_pow);
    values_pending.push_back(-ten_pow);
    ten_pow = ten_pow * 100;
    values_pending.push_back(ten_pow);
    values_pending.push_back(-(ten_pow - 1));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      raw = rand_wide();
      if ($urandom_range(4) != 0) begin
        bits = $urandom_range(MAG_W - 1, 0);
        raw  = raw & ((128'd1 << bits) - 1);
        if ($urandom_range(1)) raw = -raw;
      end
      values_pending.push_back(raw);
    end
    total_values = values_pending.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (values_pending.size() != 0 || in_valid_i || digits_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Converted %0d values (zero, unit, sign-boundary and extreme magnitudes included)",
             total_values);
    $display("into %0d checked digit items under three flow-control mixes and one long stall.",
             digits_checked);
    if (error_count == 0) begin
      $display("int128_to_base10000_digits regression: pass");
    end else begin
      $display("int128_to_base10000_digits regression: fail");
    end
    $finish;
  end

endmodule
